>>> sv/mm_pkg.sv
// shared types and constants for the matrix multiply block
package mm_pkg;

    localparam int MODE_W  = 2;
    localparam int IDX_FW  = 5;
    localparam int VALUE_W = 32;
    localparam int PROD_W  = 64;
    localparam int SIZE_W  = 6;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

    localparam logic [PROD_W-1:0] PROD_POS_MAX = {1'b0, {(PROD_W-1){1'b1}}};
    localparam logic [PROD_W-1:0] PROD_NEG_MAX = {1'b1, {(PROD_W-1){1'b0}}};

    typedef enum logic [MODE_W-1:0] {
        MODE_WR_A = 2'd0,
        MODE_WR_B = 2'd1,
        MODE_RD_C = 2'd2
    } mode_t;

    typedef struct packed {
        logic clear;
        logic load;
    } mac_ctrl_t;

endpackage

>>> sv/mm_mem.sv
// single-port-write, single-port-read element store with registered read data
module mm_mem
    import mm_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/mm_mac.sv
// shared multiply-accumulate unit with registered product
module mm_mac
    import mm_pkg::*;
#(
    parameter int ACC_W = 70
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mac_ctrl_t                 ctrl,
    input  logic signed [VALUE_W-1:0] a,
    input  logic signed [VALUE_W-1:0] b,
    output logic signed [ACC_W-1:0]   acc,
    output logic                      busy
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctrl.load;
        end
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = prod_vld_reg;

endmodule

>>> sv/matrix_multiply.sv
// matrix multiply top level: element stores, read sequencer and result register
//
//  channel | dir | handshake           | contents
//  s_      | in  | s_tvalid / s_tready | tuser mode, tdata row, col, value
//  m_      | out | m_tvalid / m_tready | tuser saturated, tdata out_row, out_col, product
//  cfg_    | in  | cfg_we              | cfg_wdata size in use
//
// a write request goes straight into its store; a read request inside the matrix walks k
// over 0..n-1, n being the effective size, with one shared multiply-accumulate step per k
// behind the registered store reads; a read outside the matrix goes straight to the result
// synchronous active-low reset clears control state only; the stores hold no reset value
// a finished result waits in the output register, and write requests are still taken
module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_N = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [SIZE_W-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // row, col, value
    input  logic [MODE_W-1:0]     s_tuser,   // mode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_row, out_col, product
    output logic                  m_tuser    // saturated
);

    localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int N_W   = $clog2(MAX_N + 1);
    localparam int ACC_W = PROD_W + IDX_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ISSUE  = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0]  size_reg;
    logic [N_W-1:0]     n_eff;
    logic [IDX_FW-1:0]  row_reg, col_reg;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic               rd_vld_reg;

    logic               m_tvalid_reg;
    logic [IDX_FW-1:0]  out_row_reg, out_col_reg;
    logic [PROD_W-1:0]  product_reg;
    logic               sat_reg;

    logic [IDX_FW-1:0]  in_row, in_col;
    logic [VALUE_W-1:0] in_value;
    mode_t              in_mode;
    logic               in_accept, in_range, last_k, out_load;

    logic               a_we, b_we;
    logic [AW-1:0]      wr_addr, a_rd_addr, b_rd_addr;
    logic [VALUE_W-1:0] a_rd_data, b_rd_data;

    mac_ctrl_t                mac_ctrl;
    logic signed [ACC_W-1:0]  acc;
    logic                     mac_busy;
    logic                     ovf;
    logic [PROD_W-1:0]        sat_value;

    assign in_row   = s_tdata[IDX_FW-1:0];
    assign in_col   = s_tdata[2*IDX_FW-1:IDX_FW];
    assign in_value = s_tdata[2*IDX_FW+VALUE_W-1:2*IDX_FW];
    assign in_mode  = mode_t'(s_tuser);

    // effective size clamped to 1..MAX_N
    always_comb begin
        if (size_reg == '0) begin
            n_eff = N_W'(1);
        end else if (32'(size_reg) > MAX_N) begin
            n_eff = N_W'(MAX_N);
        end else begin
            n_eff = N_W'(size_reg);
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_range  = (32'(in_row) < 32'(n_eff)) && (32'(in_col) < 32'(n_eff));
    assign last_k    = (32'(k_reg) == 32'(n_eff) - 32'd1);
    assign out_load  = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    // store write and read addresses
    assign wr_addr   = AW'(in_row) * AW'(MAX_N) + AW'(in_col);
    assign a_rd_addr = AW'(row_reg) * AW'(MAX_N) + AW'(k_reg);
    assign b_rd_addr = AW'(k_reg) * AW'(MAX_N) + AW'(col_reg);

    always_comb begin
        a_we = 1'b0;
        b_we = 1'b0;
        if (in_accept && in_range) begin
            case (in_mode)
                MODE_WR_A: a_we = 1'b1;
                MODE_WR_B: b_we = 1'b1;
                default: begin
                    a_we = 1'b0;
                    b_we = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        mac_ctrl.clear = 1'b0;
        mac_ctrl.load  = rd_vld_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && in_mode == MODE_RD_C) begin
                    mac_ctrl.clear = 1'b1;
                    k_next         = '0;
                    state_next     = in_range ? ST_ISSUE : ST_FINISH;
                end
            end
            ST_ISSUE: begin
                k_next = k_reg + IDX_W'(1);
                if (last_k) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_vld_reg && !mac_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // saturate the exact sum to the signed 64-bit range
    assign ovf = !((&acc[ACC_W-1:PROD_W-1]) || (~|acc[ACC_W-1:PROD_W-1]));
    assign sat_value = acc[ACC_W-1] ? PROD_NEG_MAX : PROD_POS_MAX;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            size_reg     <= SIZE_RESET;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            k_reg        <= '0;
        end else begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            rd_vld_reg <= (state_reg == ST_ISSUE);
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            row_reg <= in_row;
            col_reg <= in_col;
        end
        if (out_load) begin
            out_row_reg <= row_reg;
            out_col_reg <= col_reg;
            product_reg <= ovf ? sat_value : acc[PROD_W-1:0];
            sat_reg     <= ovf;
        end
    end

    mm_mem #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_W),
        .AW    (AW)
    ) u_store_a (
        .aclk    (aclk),
        .we      (a_we),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    mm_mem #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_W),
        .AW    (AW)
    ) u_store_b (
        .aclk    (aclk),
        .we      (b_we),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    mm_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .a       (a_rd_data),
        .b       (b_rd_data),
        .acc     (acc),
        .busy    (mac_busy)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'({product_reg, out_col_reg, out_row_reg});
    assign m_tuser  = sat_reg;

    // a clamped result carries one of the two range limits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (product_reg == PROD_POS_MAX) || (product_reg == PROD_NEG_MAX))
        else $error("saturated result not at a range limit");

    // the sum is taken only after every product has been accumulated
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH |-> !rd_vld_reg && !mac_busy)
        else $error("result taken while accumulation in flight");

    // the k walk stays inside the effective size
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ISSUE |-> 32'(k_reg) < 32'(n_eff))
        else $error("k index beyond matrix size");

    // a pending result is never overwritten before it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(product_reg) && $stable(sat_reg))
        else $error("pending result overwritten");

endmodule
